/* rtl/aip_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_pkg: shared types and constants for the ASCII integer list parser
// Character codes, field widths and the classified token that passes from
// the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 16;
    localparam int DIGIT_W = 4;

    // Magnitude after one shift-add step by ten: 32 bits plus four of growth
    localparam int WIDE_W  = VALUE_W + 4;

    localparam logic [CHAR_W-1:0] CHAR_TERM  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [COUNT_W-1:0] MAX_VALUES_RESET = 16'd16;

    // Default depth of the queue between front and back end
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic [1:0] {
        KIND_TERM,
        KIND_DIGIT,
        KIND_MINUS,
        KIND_OTHER
    } char_kind_t;

    typedef struct packed {
        char_kind_t         kind;
        logic [DIGIT_W-1:0] digit;
    } token_t;

endpackage

/* rtl/aip_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_if: channel interfaces of the ASCII integer list parser
// Character byte channel and result channel, each with valid/ready.
// ----------------------------------------------------------------------------
interface aip_byte_if;
    logic                         valid;
    logic                         ready;
    logic [aip_pkg::CHAR_W-1:0]   char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

interface aip_result_if;
    logic                                valid;
    logic                                ready;
    logic                                has_value;
    logic signed [aip_pkg::VALUE_W-1:0]  value;
    logic [aip_pkg::COUNT_W-1:0]         value_index;
    logic                                overflow;
    logic                                end_of_string;
    logic [aip_pkg::COUNT_W-1:0]         total_count;

    modport source (output valid, output has_value, output value, output value_index,
                    output overflow, output end_of_string, output total_count,
                    input ready);
    modport sink   (input valid, input has_value, input value, input value_index,
                    input overflow, input end_of_string, input total_count,
                    output ready);
endinterface

/* rtl/aip_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_front: character classifier
// Accepts one byte per transaction while the queue has room and turns it
// into a token: terminator, digit with its value, minus sign or other.
// ----------------------------------------------------------------------------
module aip_front (
    aip_byte_if.sink          chars,
    input  logic              queue_full,
    output logic              push,
    output aip_pkg::token_t   token
);
    import aip_pkg::*;

    logic is_digit;

    // Accept whenever the queue can take the token
    assign chars.ready = !queue_full;
    assign push        = chars.valid && !queue_full;

    // Classify the byte
    assign is_digit = (chars.char_byte >= CHAR_ZERO) && (chars.char_byte <= CHAR_NINE);

    always_comb
    begin
        token.digit = DIGIT_W'(chars.char_byte - CHAR_ZERO);
        if (chars.char_byte == CHAR_TERM)
        begin
            token.kind = KIND_TERM;
        end
        else if (is_digit)
        begin
            token.kind = KIND_DIGIT;
        end
        else if (chars.char_byte == CHAR_MINUS)
        begin
            token.kind = KIND_MINUS;
        end
        else
        begin
            token.kind = KIND_OTHER;
        end
    end

endmodule

/* rtl/aip_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_queue: token queue between front and back end
// Small circular FIFO; a push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module aip_queue #(
    parameter int DEPTH = aip_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  aip_pkg::token_t   push_token,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output aip_pkg::token_t   head_token
);
    import aip_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    token_t            mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_token = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store tokens
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_token;
        end
    end

endmodule

/* rtl/aip_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_back: number builder and result stage
// Executes one token per cycle unless a result is held back by a busy output
// stage: shift-add by ten on digits, sign tracking, emission of finished
// numbers and the end-of-string summary into a registered output stage.
// ----------------------------------------------------------------------------
module aip_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [aip_pkg::COUNT_W-1:0]       max_values,
    input  logic                              head_valid,
    input  aip_pkg::token_t                   head_token,
    output logic                              pop,
    aip_result_if.source                      results
);
    import aip_pkg::*;

    // Number state
    logic [VALUE_W-1:0]  acc_reg,      acc_next;
    logic                neg_reg,      neg_next;
    logic                in_num_reg,   in_num_next;
    logic                ovf_reg,      ovf_next;
    logic [COUNT_W-1:0]  emitted_reg,  emitted_next;

    // Output stage
    logic                out_valid_reg;
    logic                has_value_reg,  has_value_next;
    logic [VALUE_W-1:0]  value_reg,      value_next;
    logic [COUNT_W-1:0]  index_reg,      index_next;
    logic                out_ovf_reg,    out_ovf_next;
    logic                eos_reg,        eos_next;
    logic [COUNT_W-1:0]  total_reg,      total_next;

    logic                room;
    logic                emit;
    logic                out_free;
    logic [WIDE_W-1:0]   wide_sum;
    logic [VALUE_W-1:0]  signed_acc;

    assign room       = (emitted_reg < max_values);
    assign out_free   = !out_valid_reg || results.ready;
    assign signed_acc = neg_reg ? (VALUE_W'(0) - acc_reg) : acc_reg;

    // acc*10 + digit as (acc<<3) + (acc<<1) + digit
    assign wide_sum = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + WIDE_W'(head_token.digit);

    // Decide whether this token gives a result
    always_comb
    begin
        priority case (1'b1)
            (head_token.kind == KIND_TERM):  emit = 1'b1;
            (!room):                         emit = 1'b0;
            (head_token.kind == KIND_DIGIT): emit = 1'b0;
            default:                         emit = in_num_reg;
        endcase
    end

    // Drop the head once it can complete
    assign pop = head_valid && (!emit || out_free);

    // Next number state and result fields
    always_comb
    begin
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        in_num_next    = in_num_reg;
        ovf_next       = ovf_reg;
        emitted_next   = emitted_reg;
        has_value_next = 1'b0;
        value_next     = '0;
        index_next     = '0;
        out_ovf_next   = 1'b0;
        eos_next       = 1'b0;
        total_next     = '0;

        if (head_token.kind == KIND_TERM)
        begin
            if (in_num_reg && room)
            begin
                has_value_next = 1'b1;
                value_next     = signed_acc;
                index_next     = emitted_reg;
                out_ovf_next   = ovf_reg;
                total_next     = emitted_reg + 1'b1;
            end
            else
            begin
                total_next     = emitted_reg;
            end
            eos_next     = 1'b1;
            acc_next     = '0;
            neg_next     = 1'b0;
            in_num_next  = 1'b0;
            ovf_next     = 1'b0;
            emitted_next = '0;
        end
        else if (room)
        begin
            if (head_token.kind == KIND_DIGIT)
            begin
                acc_next    = wide_sum[VALUE_W-1:0];
                ovf_next    = ovf_reg || (wide_sum[WIDE_W-1:VALUE_W-1] != '0);
                in_num_next = 1'b1;
            end
            else
            begin
                if (in_num_reg)
                begin
                    has_value_next = 1'b1;
                    value_next     = signed_acc;
                    index_next     = emitted_reg;
                    out_ovf_next   = ovf_reg;
                    emitted_next   = emitted_reg + 1'b1;
                    acc_next       = '0;
                    in_num_next    = 1'b0;
                    ovf_next       = 1'b0;
                end
                neg_next = (head_token.kind == KIND_MINUS);
            end
        end
    end

    // Hold number state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            neg_reg     <= 1'b0;
            in_num_reg  <= 1'b0;
            ovf_reg     <= 1'b0;
            emitted_reg <= '0;
        end
        else if (pop)
        begin
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            in_num_reg  <= in_num_next;
            ovf_reg     <= ovf_next;
            emitted_reg <= emitted_next;
        end
    end

    // Output valid: load on emission, clear once the transaction is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            has_value_reg <= has_value_next;
            value_reg     <= value_next;
            index_reg     <= index_next;
            out_ovf_reg   <= out_ovf_next;
            eos_reg       <= eos_next;
            total_reg     <= total_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.has_value     = has_value_reg;
    assign results.value         = signed'(value_reg);
    assign results.value_index   = index_reg;
    assign results.overflow      = out_ovf_reg;
    assign results.end_of_string = eos_reg;
    assign results.total_count   = total_reg;

endmodule

/* rtl/ascii_integer_list_parser.sv */
`timescale 1ns / 1ps
// A token is registered in the queue and a result in the output stage.
// Throughput: one byte per cycle while results are taken; the back end does the
// shift-add by ten, and the default two-entry queue and output register absorb stalls.
// Reset: asynchronous, active low; clears the queue, the number state and the
// output valid flag, and sets max_values to 16.
// ----------------------------------------------------------------------------
// ascii_integer_list_parser: top level
// Extracts signed decimal integers from a zero-terminated character stream:
// classifier front end, token queue, and number-building back end.
// ----------------------------------------------------------------------------
module ascii_integer_list_parser #(
    parameter int QUEUE_DEPTH = aip_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    aip_byte_if.sink                       chars,
    aip_result_if.source                   results,
    input  logic                           cfg_wr_en,
    input  logic [aip_pkg::COUNT_W-1:0]    cfg_wr_data
);
    import aip_pkg::*;

    logic [COUNT_W-1:0] max_values_reg;
    logic               push;
    logic               pop;
    logic               queue_full;
    logic               head_valid;
    token_t             push_token;
    token_t             head_token;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_values_reg <= MAX_VALUES_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_values_reg <= cfg_wr_data;
        end
    end

    aip_front u_front (
        .chars      (chars),
        .queue_full (queue_full),
        .push       (push),
        .token      (push_token)
    );

    aip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_token (push_token),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_token (head_token)
    );

    aip_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_values (max_values_reg),
        .head_valid (head_valid),
        .head_token (head_token),
        .pop        (pop),
        .results    (results)
    );

endmodule
